@@ hdl/fxs_pkg.sv @@
// Shared types and constants for the framed XOR stream cipher.
package fxs_pkg;

   // Default key length in bytes.
   localparam int KEY_BYTES_DEFAULT = 32;

   // Frame header layout.
   localparam logic [7:0] MAGIC0    = 8'hAA;
   localparam logic [7:0] MAGIC1    = 8'hBB;
   localparam logic [2:0] HDR_BYTES = 3'd4;

   // Register map: master words first, then session words.
   localparam logic [2:0] CSR_MASTER_WORD0  = 3'd0;
   localparam logic [2:0] CSR_SESSION_WORD0 = 3'd4;

   // Request function codes.
   typedef enum logic [1:0] {
      FUNC_BEGIN_ENC = 2'd0,
      FUNC_ENC_BYTE  = 2'd1,
      FUNC_DEC_BYTE  = 2'd2,
      FUNC_BEGIN_DEC = 2'd3
   } func_type;

   // Message status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_MAGIC = 2'd1,
      STATUS_TOO_SHORT = 2'd2
   } status_type;

   // Work handed from the framing logic to the response sequencer.
   typedef struct packed {
      logic        hdr;
      logic        emit_byte;
      logic        emit_status;
      status_type  status;
      logic [7:0]  data;
      logic [7:0]  idx_lo;
      logic [15:0] len;
   } rsp_desc_type;

endpackage

@@ hdl/framed_xor_stream_cipher.sv @@
// Top level of the framed XOR stream cipher.
//
//   Channel  Direction  Beat carries
//   req_     in         func, data_in, msg_len, end_of_message
//   rsp_     out        out_byte, end_of_run, message_done, status
//   csr_     in         register index and 64-bit write data
//
// Encrypt and decrypt bytes are taken one per cycle while no key sweep runs and the response
// sequencer is free; a decrypt byte that yields both a payload byte and the status occupies
// the sequencer for a payload beat and a status beat, and a begin encrypt for four header beats.
// A begin encrypt or begin decrypt starts a key sweep through the key memory write port;
// requests and register writes wait until it completes.
// Reset clears the key registers and framing state; the key memory holds no value until
// the first begin. A stalled response holds the sequencer, which then holds the request.
module framed_xor_stream_cipher import fxs_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_in,
   input  logic [15:0] req_msg_len,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_run,
   output logic        rsp_message_done,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int KAW = $clog2(KEY_BYTES);

   logic           deriving;
   logic           derive_start;
   logic           key_wr_en;
   logic [KAW-1:0] key_wr_addr;
   logic [7:0]     key_wr_data;
   logic [KAW-1:0] key_addr_a;
   logic [KAW-1:0] key_addr_b;
   logic [7:0]     key_a;
   logic [7:0]     key_b;
   logic           req_accept;
   logic           desc_load;
   logic           desc_free;
   rsp_desc_type   desc;

   // Handshakes: the sweep blocks both input channels.
   assign req_ready  = !deriving && desc_free;
   assign csr_ready  = !deriving;
   assign req_accept = req_valid && req_ready;

   fxs_csr #(.KEY_BYTES(KEY_BYTES)) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .derive_start (derive_start),
      .deriving     (deriving),
      .key_wr_en    (key_wr_en),
      .key_wr_addr  (key_wr_addr),
      .key_wr_data  (key_wr_data)
   );

   fxs_key_ram #(.KEY_BYTES(KEY_BYTES)) u_key_ram (
      .clock     (clock),
      .wr_en     (key_wr_en),
      .wr_addr   (key_wr_addr),
      .wr_data   (key_wr_data),
      .rd_en     (req_accept),
      .rd_addr_a (key_addr_a),
      .rd_addr_b (key_addr_b),
      .rd_data_a (key_a),
      .rd_data_b (key_b)
   );

   fxs_frame #(.KEY_BYTES(KEY_BYTES)) u_frame (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .func           (req_func),
      .data_in        (req_data_in),
      .msg_len        (req_msg_len),
      .end_of_message (req_end_of_message),
      .derive_start   (derive_start),
      .desc_load      (desc_load),
      .desc           (desc),
      .key_addr_a     (key_addr_a),
      .key_addr_b     (key_addr_b)
   );

   fxs_rsp u_rsp (
      .clock            (clock),
      .reset            (reset),
      .desc_load        (desc_load),
      .desc             (desc),
      .key_a            (key_a),
      .key_b            (key_b),
      .desc_free        (desc_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_message_done (rsp_message_done),
      .rsp_status       (rsp_status)
   );

endmodule

@@ hdl/fxs_key_ram.sv @@
// Derived key memory: one write port, two registered read ports.
module fxs_key_ram import fxs_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(KEY_BYTES)-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(KEY_BYTES)-1:0] rd_addr_a,
   input  logic [$clog2(KEY_BYTES)-1:0] rd_addr_b,
   output logic [7:0]                   rd_data_a,
   output logic [7:0]                   rd_data_b
);

   logic [7:0] key_mem [KEY_BYTES];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   // Read ports hold their data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= key_mem[rd_addr_a];
         rd_b_ff <= key_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/fxs_csr.sv @@
// Key registers and the key derivation sweep into the key memory.
module fxs_csr import fxs_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [63:0]                  csr_data,
   input  logic                         derive_start,
   output logic                         deriving,
   output logic                         key_wr_en,
   output logic [$clog2(KEY_BYTES)-1:0] key_wr_addr,
   output logic [7:0]                   key_wr_data
);

   localparam int KAW = $clog2(KEY_BYTES);

   logic [63:0]    master_ff  [4];
   logic [63:0]    session_ff [4];
   logic           deriving_ff;
   logic           deriving_in;
   logic [KAW-1:0] sweep_cnt_ff;
   logic [KAW-1:0] sweep_cnt_in;
   logic [4:0]     j_full;
   logic [1:0]     word_sel;
   logic [7:0]     m_byte;
   logic [7:0]     s_byte;

   // Configuration writes; the word offset is taken within each bank.
   assign word_sel = (csr_index >= CSR_SESSION_WORD0) ? 2'(csr_index - CSR_SESSION_WORD0)
                                                      : 2'(csr_index - CSR_MASTER_WORD0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < 4; w++) begin
            master_ff[w]  <= '0;
            session_ff[w] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index >= CSR_SESSION_WORD0) begin
            session_ff[word_sel] <= csr_data;
         end else begin
            master_ff[word_sel] <= csr_data;
         end
      end
   end

   // Sweep control: one key byte per cycle.
   always_comb begin
      deriving_in  = deriving_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (deriving_ff) begin
         sweep_cnt_in = sweep_cnt_ff + KAW'(1);
         if (sweep_cnt_ff == KAW'(KEY_BYTES - 1)) begin
            deriving_in  = 1'b0;
            sweep_cnt_in = '0;
         end
      end else if (derive_start) begin
         deriving_in  = 1'b1;
         sweep_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deriving_ff  <= 1'b0;
         sweep_cnt_ff <= '0;
      end else begin
         deriving_ff  <= deriving_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // Key byte j is (master j XOR session j) plus j.
   assign j_full = 5'(sweep_cnt_ff);
   assign m_byte = master_ff[j_full[4:3]][{j_full[2:0], 3'b000} +: 8];
   assign s_byte = session_ff[j_full[4:3]][{j_full[2:0], 3'b000} +: 8];

   assign deriving    = deriving_ff;
   assign key_wr_en   = deriving_ff;
   assign key_wr_addr = sweep_cnt_ff;
   assign key_wr_data = (m_byte ^ s_byte) + 8'(j_full);

endmodule

@@ hdl/fxs_frame.sv @@
// Framing state: byte index, header parsing, key addresses and status.
module fxs_frame import fxs_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [1:0]                   func,
   input  logic [7:0]                   data_in,
   input  logic [15:0]                  msg_len,
   input  logic                         end_of_message,
   output logic                         derive_start,
   output logic                         desc_load,
   output rsp_desc_type                 desc,
   output logic [$clog2(KEY_BYTES)-1:0] key_addr_a,
   output logic [$clog2(KEY_BYTES)-1:0] key_addr_b
);

   localparam int KAW = $clog2(KEY_BYTES);

   func_type       func_code;
   logic [15:0]    byte_index_ff, byte_index_in;
   logic [15:0]    payload_length_ff, payload_length_in;
   logic [2:0]     header_count_ff, header_count_in;
   logic           bad_magic_ff, bad_magic_in;
   logic [KAW-1:0] addr_a_ff, addr_a_in;
   logic [KAW-1:0] addr_b_ff, addr_b_in;
   logic [KAW:0]   sum_a;
   logic [KAW:0]   sum_b;
   logic [KAW-1:0] step_a;
   logic [KAW-1:0] step_b;

   assign func_code = func_type'(func);

   // Running 3i and 7i modulo the key length.
   assign sum_a  = {1'b0, addr_a_ff} + (KAW+1)'(3);
   assign sum_b  = {1'b0, addr_b_ff} + (KAW+1)'(7);
   assign step_a = (sum_a >= (KAW+1)'(KEY_BYTES)) ? KAW'(sum_a - (KAW+1)'(KEY_BYTES))
                                                  : KAW'(sum_a);
   assign step_b = (sum_b >= (KAW+1)'(KEY_BYTES)) ? KAW'(sum_b - (KAW+1)'(KEY_BYTES))
                                                  : KAW'(sum_b);

   // Next state and the work descriptor for the accepted beat.
   always_comb begin
      byte_index_in     = byte_index_ff;
      payload_length_in = payload_length_ff;
      header_count_in   = header_count_ff;
      bad_magic_in      = bad_magic_ff;
      addr_a_in         = addr_a_ff;
      addr_b_in         = addr_b_ff;
      desc_load         = 1'b0;
      derive_start      = 1'b0;
      desc              = '0;
      desc.data         = data_in;
      desc.idx_lo       = byte_index_ff[7:0];
      desc.len          = msg_len;
      if (accept) begin
         unique case (func_code)
            FUNC_BEGIN_ENC: begin
               derive_start      = 1'b1;
               byte_index_in     = '0;
               payload_length_in = msg_len;
               header_count_in   = '0;
               bad_magic_in      = 1'b0;
               addr_a_in         = '0;
               addr_b_in         = '0;
               desc_load         = 1'b1;
               desc.hdr          = 1'b1;
            end
            FUNC_ENC_BYTE: begin
               desc_load      = 1'b1;
               desc.emit_byte = 1'b1;
               byte_index_in  = byte_index_ff + 16'd1;
               addr_a_in      = (byte_index_ff == 16'hFFFF) ? '0 : step_a;
               addr_b_in      = (byte_index_ff == 16'hFFFF) ? '0 : step_b;
            end
            FUNC_BEGIN_DEC: begin
               derive_start      = 1'b1;
               byte_index_in     = '0;
               payload_length_in = '0;
               header_count_in   = '0;
               bad_magic_in      = 1'b0;
               addr_a_in         = '0;
               addr_b_in         = '0;
            end
            FUNC_DEC_BYTE: begin
               if (header_count_ff < HDR_BYTES) begin
                  unique case (header_count_ff[1:0])
                     2'd0: if (data_in != MAGIC0) bad_magic_in = 1'b1;
                     2'd1: if (data_in != MAGIC1) bad_magic_in = 1'b1;
                     2'd2: payload_length_in = {payload_length_ff[15:8], data_in};
                     2'd3: payload_length_in = {data_in, payload_length_ff[7:0]};
                  endcase
                  header_count_in = header_count_ff + 3'd1;
               end else if (byte_index_ff < payload_length_ff) begin
                  desc.emit_byte = 1'b1;
                  byte_index_in  = byte_index_ff + 16'd1;
                  addr_a_in      = (byte_index_ff == 16'hFFFF) ? '0 : step_a;
                  addr_b_in      = (byte_index_ff == 16'hFFFF) ? '0 : step_b;
               end
               if (end_of_message) begin
                  desc.emit_status = 1'b1;
                  if (header_count_in < HDR_BYTES) begin
                     desc.status = STATUS_TOO_SHORT;
                  end else if (bad_magic_in) begin
                     desc.status = STATUS_BAD_MAGIC;
                  end else if (byte_index_in < payload_length_in) begin
                     desc.status = STATUS_TOO_SHORT;
                  end else begin
                     desc.status = STATUS_OK;
                  end
                  byte_index_in     = '0;
                  payload_length_in = '0;
                  header_count_in   = '0;
                  bad_magic_in      = 1'b0;
                  addr_a_in         = '0;
                  addr_b_in         = '0;
               end
               desc_load = desc.emit_byte | desc.emit_status;
            end
            default: begin
               desc_load = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= '0;
         payload_length_ff <= '0;
         header_count_ff   <= '0;
         bad_magic_ff      <= 1'b0;
         addr_a_ff         <= '0;
         addr_b_ff         <= '0;
      end else begin
         byte_index_ff     <= byte_index_in;
         payload_length_ff <= payload_length_in;
         header_count_ff   <= header_count_in;
         bad_magic_ff      <= bad_magic_in;
         addr_a_ff         <= addr_a_in;
         addr_b_ff         <= addr_b_in;
      end
   end

   // The key is read at the addresses of the current byte index.
   assign key_addr_a = addr_a_ff;
   assign key_addr_b = addr_b_ff;

   // The header counter saturates at the header length.
   a_hdr_count_max: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HDR_BYTES)
      else $error("header count ran past the header length");

   // Key addresses stay inside the key.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (addr_a_ff < KAW'(KEY_BYTES - 1) || addr_a_ff == KAW'(KEY_BYTES - 1)) &&
      (addr_b_ff < KAW'(KEY_BYTES - 1) || addr_b_ff == KAW'(KEY_BYTES - 1)))
      else $error("key address outside the key");

   // End of message leaves a clean frame.
   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && func_code == FUNC_DEC_BYTE && end_of_message) |=>
      (header_count_ff == 3'd0 && byte_index_ff == 16'd0 && !bad_magic_ff))
      else $error("frame state not cleared after end of message");

endmodule

@@ hdl/fxs_rsp.sv @@
// Response sequencer: expands one work descriptor into result beats.
module fxs_rsp import fxs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         desc_load,
   input  rsp_desc_type desc,
   input  logic [7:0]   key_a,
   input  logic [7:0]   key_b,
   output logic         desc_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_end_of_run,
   output logic         rsp_message_done,
   output logic [1:0]   rsp_status
);

   logic         s1_valid_ff, s1_valid_in;
   rsp_desc_type s1_desc_ff;
   logic [1:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff;
   logic [7:0]   rsp_out_byte_ff;
   logic         rsp_end_of_run_ff;
   logic         rsp_message_done_ff;
   status_type   rsp_status_ff;
   logic         push;
   logic         last;
   logic         is_status;
   logic [7:0]   cipher;
   logic [7:0]   res_byte;

   assign push   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign cipher = s1_desc_ff.data ^ key_a ^ key_b ^ s1_desc_ff.idx_lo;

   // Pick the result for the current step of the descriptor.
   always_comb begin
      is_status = 1'b0;
      res_byte  = cipher;
      last      = 1'b1;
      if (s1_desc_ff.hdr) begin
         unique case (cnt_ff)
            2'd0: res_byte = MAGIC0;
            2'd1: res_byte = MAGIC1;
            2'd2: res_byte = s1_desc_ff.len[7:0];
            2'd3: res_byte = s1_desc_ff.len[15:8];
         endcase
         last = (cnt_ff == 2'd3);
      end else begin
         is_status = !(s1_desc_ff.emit_byte && cnt_ff == 2'd0);
         res_byte  = is_status ? 8'd0 : cipher;
         last      = is_status || !s1_desc_ff.emit_status;
      end
   end

   // Descriptor holding stage.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      cnt_in      = cnt_ff;
      if (push) begin
         if (last) begin
            s1_valid_in = 1'b0;
            cnt_in      = '0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
      if (desc_load) begin
         s1_valid_in = 1'b1;
         cnt_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_load) begin
         s1_desc_ff <= desc;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_out_byte_ff     <= res_byte;
         rsp_end_of_run_ff   <= last;
         rsp_message_done_ff <= is_status;
         rsp_status_ff       <= is_status ? s1_desc_ff.status : STATUS_OK;
      end
   end

   assign desc_free        = !s1_valid_ff || (push && last);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_end_of_run   = rsp_end_of_run_ff;
   assign rsp_message_done = rsp_message_done_ff;
   assign rsp_status       = rsp_status_ff;

   // A held descriptor keeps its place while the output is blocked.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !push) |=> (s1_valid_ff && $stable(cnt_ff)))
      else $error("descriptor lost while output stalled");

   // Data descriptors produce at most two results.
   a_data_steps: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_desc_ff.hdr) |-> (cnt_ff == 2'd0 || cnt_ff == 2'd1))
      else $error("data descriptor stepped too far");

   // A status beat closes its run and carries no byte.
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_message_done_ff) |->
      (rsp_end_of_run_ff && rsp_out_byte_ff == 8'd0))
      else $error("malformed status beat");

endmodule

@@ test/tb_cipher_pkg.sv @@
`timescale 1ns / 100ps
// Response predictor and scoreboard for the framed XOR stream cipher testbench.
package tb_cipher_pkg;
   import fxs_pkg::*;

   localparam int KEY_LEN = KEY_BYTES_DEFAULT;

   // One response beat as seen on the rsp_ channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       message_done;
      logic [1:0] status;
   } rsp_beat_type;

   class cipher_scoreboard;
      logic [63:0]  master_word [4];
      logic [63:0]  session_word [4];
      logic [7:0]   key_copy [KEY_LEN];
      logic [15:0]  byte_index;
      logic [15:0]  payload_length;
      logic [2:0]   header_count;
      logic         bad_magic;
      rsp_beat_type predicted_rsp [$];
      int           mismatches;
      int           beats_checked;
      int           status_count [3];

      function new();
         foreach (master_word[w]) begin
            master_word[w]  = '0;
            session_word[w] = '0;
         end
         foreach (key_copy[j]) key_copy[j] = '0;
         foreach (status_count[s]) status_count[s] = 0;
         clear_frame();
         mismatches    = 0;
         beats_checked = 0;
      endfunction

      // Master words sit below the session words in the register map.
      function void write_register(logic [2:0] index, logic [63:0] value);
         if (index < CSR_SESSION_WORD0) master_word[index[1:0]] = value;
         else session_word[index[1:0]] = value;
      endfunction

      // Each key byte is the XOR of master and session bytes plus its position.
      function void build_key();
         logic [7:0] mb;
         logic [7:0] sb;
         for (int j = 0; j < KEY_LEN; j++) begin
            mb = master_word[j / 8][8 * (j % 8) +: 8];
            sb = session_word[j / 8][8 * (j % 8) +: 8];
            key_copy[j] = (mb ^ sb) + 8'(j);
         end
      endfunction

      function logic [7:0] keystream(logic [15:0] i);
         int a;
         int b;
         a = (int'(i) * 3) % KEY_LEN;
         b = (int'(i) * 7) % KEY_LEN;
         return key_copy[a] ^ key_copy[b] ^ i[7:0];
      endfunction

      function void clear_frame();
         byte_index     = '0;
         payload_length = '0;
         header_count   = '0;
         bad_magic      = 1'b0;
      endfunction

      function void queue_beat(logic [7:0] value, logic last, logic done, status_type st);
         rsp_beat_type beat;
         beat.out_byte     = value;
         beat.end_of_run   = last;
         beat.message_done = done;
         beat.status       = st;
         predicted_rsp.insert(predicted_rsp.size(), beat);
      endfunction

      // Work out the response beats caused by one accepted request beat.
      function void predict_request(func_type func, logic [7:0] data, logic [15:0] len,
                                    logic eom);
         status_type st;
         case (func)
            FUNC_BEGIN_ENC: begin
               build_key();
               clear_frame();
               payload_length = len;
               queue_beat(MAGIC0, 1'b0, 1'b0, STATUS_OK);
               queue_beat(MAGIC1, 1'b0, 1'b0, STATUS_OK);
               queue_beat(len[7:0], 1'b0, 1'b0, STATUS_OK);
               queue_beat(len[15:8], 1'b1, 1'b0, STATUS_OK);
            end
            FUNC_ENC_BYTE: begin
               // Ciphered regardless of the announced length.
               queue_beat(data ^ keystream(byte_index), 1'b1, 1'b0, STATUS_OK);
               byte_index++;
            end
            FUNC_BEGIN_DEC: begin
               build_key();
               clear_frame();
            end
            FUNC_DEC_BYTE: begin
               // Header bytes are consumed silently; surplus payload is dropped.
               if (header_count < HDR_BYTES) begin
                  case (header_count)
                     3'd0: if (data != MAGIC0) bad_magic = 1'b1;
                     3'd1: if (data != MAGIC1) bad_magic = 1'b1;
                     3'd2: payload_length[7:0] = data;
                     default: payload_length[15:8] = data;
                  endcase
                  header_count++;
               end else if (byte_index < payload_length) begin
                  queue_beat(data ^ keystream(byte_index), !eom, 1'b0, STATUS_OK);
                  byte_index++;
               end
               // The status beat follows any payload beat of the same request.
               if (eom) begin
                  if (header_count < HDR_BYTES) st = STATUS_TOO_SHORT;
                  else if (bad_magic) st = STATUS_BAD_MAGIC;
                  else if (byte_index < payload_length) st = STATUS_TOO_SHORT;
                  else st = STATUS_OK;
                  queue_beat(8'h00, 1'b1, 1'b1, st);
                  status_count[int'(st)]++;
                  clear_frame();
               end
            end
         endcase
      endfunction

      // Compare an accepted response beat with the oldest prediction.
      function void check_response(rsp_beat_type actual);
         rsp_beat_type want;
         beats_checked++;
         if (predicted_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected response beat byte=%02h last=%0b done=%0b status=%0d",
                        actual.out_byte, actual.end_of_run, actual.message_done,
                        actual.status);
            return;
         end
         want = predicted_rsp.pop_front();
         if (actual.out_byte !== want.out_byte || actual.end_of_run !== want.end_of_run ||
             actual.message_done !== want.message_done || actual.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"tb: response beat %0d mismatch: expected byte=%02h last=%0b ",
                         "done=%0b status=%0d, got byte=%02h last=%0b done=%0b status=%0d"},
                        beats_checked, want.out_byte, want.end_of_run, want.message_done,
                        want.status, actual.out_byte, actual.end_of_run,
                        actual.message_done, actual.status);
         end
      endfunction

      function int pending();
         return predicted_rsp.size();
      endfunction
   endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the framed XOR stream cipher.
module tb_top;
   import fxs_pkg::*;
   import tb_cipher_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_BEGIN_ENC;
   logic [7:0]  req_data_in = '0;
   logic [15:0] req_msg_len = '0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_run;
   logic        rsp_message_done;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   cipher_scoreboard sb;
   int requests_sent = 0;
   int encrypt_messages = 0;
   int decrypt_frames = 0;
   int key_settings = 0;
   int stall_left = 0;
   bit rsp_stalls_on = 1'b1;
   bit req_gaps_on = 1'b1;

   framed_xor_stream_cipher dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted response beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_out_byte, rsp_end_of_run, rsp_message_done, rsp_status});
   end

   // Offer one request beat and hold it until accepted. Valid stays high on return
   // so that a following beat can go out back to back.
   task automatic send_request(func_type func, logic [7:0] data, logic [15:0] len,
                               logic eom);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= func;
      req_data_in        <= data;
      req_msg_len        <= len;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      sb.predict_request(func, data, len, eom);
      requests_sent++;
   endtask

   // A received frame: the first n_header header bytes, then n_payload random bytes,
   // with end of message on the last beat when close is set.
   task automatic send_frame(input logic [7:0] magic0, input logic [7:0] magic1,
                             input logic [15:0] len, input int n_header,
                             input int n_payload, input bit close);
      logic [7:0] header [4];
      int total;
      header = '{magic0, magic1, len[7:0], len[15:8]};
      total  = n_header + n_payload;
      for (int k = 0; k < total; k++)
         send_request(FUNC_DEC_BYTE, (k < n_header) ? header[k] : 8'($urandom),
                      16'($urandom), close && (k == total - 1));
      decrypt_frames++;
   endtask

   // A begin encrypt followed by n_bytes payload bytes.
   task automatic send_encrypt(logic [15:0] len, int n_bytes);
      send_request(FUNC_BEGIN_ENC, 8'($urandom), len, 1'($urandom));
      repeat (n_bytes)
         send_request(FUNC_ENC_BYTE, 8'($urandom), 16'($urandom), 1'($urandom));
      encrypt_messages++;
   endtask

   // Let all predicted beats arrive, then allow for a key sweep still in flight.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (KEY_LEN + 8) @(posedge clock);
   endtask

   initial begin
      logic [63:0] key_words [8];
      logic [2:0]  idx;
      logic [15:0] len;
      int          pick;
      int          shape;
      int          quota;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         // Key material: random, all ones, all zeros, then a checkerboard.
         foreach (key_words[i]) begin
            case (phase)
               0: key_words[i] = {$urandom, $urandom};
               1: key_words[i] = '1;
               2: key_words[i] = '0;
               default: key_words[i] = (i % 2) ? 64'h5A5A_5A5A_5A5A_5A5A
                                               : 64'hA5A5_A5A5_A5A5_A5A5;
            endcase
         end

         // Register writes, back to back, with the block idle.
         for (int i = 0; i < 8; i++) begin
            idx = (i < 4) ? CSR_MASTER_WORD0 + 3'(i) : CSR_SESSION_WORD0 + 3'(i - 4);
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_data  <= key_words[i];
            do @(posedge clock); while (!csr_ready);
            sb.write_register(idx, key_words[i]);
         end
         csr_valid <= 1'b0;
         key_settings++;

         if (phase == 0) begin
            // Directed: field extremes, every function, and each framing corner.
            send_request(FUNC_BEGIN_ENC, 8'hFF, 16'hFFFF, 1'b1);
            send_request(FUNC_ENC_BYTE, 8'h00, 16'h0000, 1'b0);
            send_request(FUNC_ENC_BYTE, 8'hFF, 16'hFFFF, 1'b1);
            send_request(FUNC_BEGIN_ENC, 8'h00, 16'h0000, 1'b0);
            send_request(FUNC_ENC_BYTE, 8'hA5, 16'h0000, 1'b0);
            send_request(FUNC_BEGIN_DEC, 8'hFF, 16'hFFFF, 1'b1);
            // Well-formed frame.
            send_frame(MAGIC0, MAGIC1, 16'd2, 4, 2, 1'b1);
            // Wrong second magic byte with a surplus byte after the payload.
            send_frame(MAGIC0, 8'h11, 16'd1, 4, 2, 1'b1);
            // Message ends inside the header.
            send_frame(MAGIC0, MAGIC1, 16'd0, 1, 0, 1'b1);
            // Payload shorter than announced.
            send_frame(MAGIC0, MAGIC1, 16'd3, 4, 1, 1'b1);
            // Zero-length payload, message ends on the last header byte.
            send_frame(MAGIC0, MAGIC1, 16'd0, 4, 0, 1'b1);
         end

         // One long message carries the byte index past 256.
         if (phase == 1) begin
            send_encrypt(16'd260, 260);
            quota = requests_sent + 30;
         end else begin
            quota = requests_sent + 45;
         end

         // Random traffic: mostly whole messages, some broken frames and loose beats.
         while (requests_sent < quota) begin
            if ($urandom_range(0, 7) == 0) begin
               rsp_stalls_on = ($urandom_range(0, 2) != 0);
               req_gaps_on   = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
               send_encrypt(len, $urandom_range(0, 12));
            end else if (pick < 80) begin
               if ($urandom_range(0, 1) != 0)
                  send_request(FUNC_BEGIN_DEC, 8'($urandom), 16'($urandom), 1'($urandom));
               len   = 16'($urandom_range(0, 10));
               shape = $urandom_range(0, 9);
               case (shape)
                  0: send_frame(8'($urandom), MAGIC1, len, 4, len, 1'b1);
                  1: send_frame(MAGIC0, 8'($urandom), len, 4, len, 1'b1);
                  2: send_frame(MAGIC0, MAGIC1, len, $urandom_range(1, 3), 0, 1'b1);
                  3: send_frame(MAGIC0, MAGIC1, 16'(len + $urandom_range(1, 4)), 4, len,
                                1'b1);
                  4: send_frame(MAGIC0, MAGIC1, len, 4, len + $urandom_range(1, 4), 1'b1);
                  5: send_frame(MAGIC0, MAGIC1, 16'($urandom), 4, len, 1'b1);
                  default: send_frame(MAGIC0, MAGIC1, len, 4, len, 1'b1);
               endcase
            end else begin
               send_request(func_type'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                            1'($urandom));
            end
         end
         wait_until_drained();
      end

      $display("tb: %0d request beats (%0d encrypt messages, %0d received frames)",
               requests_sent, encrypt_messages, decrypt_frames);
      $display("tb: %0d key settings, %0d response beats checked, status ok/bad/short %0d/%0d/%0d",
               key_settings, sb.beats_checked, sb.status_count[0], sb.status_count[1],
               sb.status_count[2]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
